/* src/ulist_pkg.sv */
// Shared types and constants for the unsorted list table.
package ulist_pkg;

   // Widths of the transaction fields.
   localparam int DATA_W = 32;
   localparam int MODE_W = 3;

   // Operation codes carried by the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT   = 3'd0,
      MODE_DELETE   = 3'd1,
      MODE_RETRIEVE = 3'd2,
      MODE_RST_CUR  = 3'd3,
      MODE_GET_NEXT = 3'd4,
      MODE_CLEAR    = 3'd5
   } mode_type;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SC_RD   = 8'b0000_0010,
      ST_SC_CMP  = 8'b0000_0100,
      ST_SH_RD   = 8'b0000_1000,
      ST_SH_WR   = 8'b0001_0000,
      ST_GN_RD   = 8'b0010_0000,
      ST_GN_DATA = 8'b0100_0000,
      ST_RESP    = 8'b1000_0000
   } state_type;

endpackage

/* src/unsorted_list_table_unit.sv */
// Unsorted list table: ordered list of signed values with front insert and a walking cursor.
//
// Usage: one request channel (req_mode, req_value) and one response channel
// (rsp_found, rsp_item_out, rsp_count, rsp_full_res, rsp_rejected), both with
// valid/stall handshakes. Every request transaction yields exactly one response
// transaction, in order. The block works on one transaction at a time and
// raises req_stall until its response has been placed in the output register.
// The list is kept in a single RAM with the front entry at the highest used
// address, so an insert is one write and a delete closes the gap by moving the
// entries ahead of the match down one address at a time.
// Insert, cursor reset, clear and unused codes go straight to the response step;
// get-next first reads the entry at the cursor unless it wraps to none; retrieve
// and delete read and compare entries front to back, at most the count, and delete
// then moves each entry ahead of the match down by a read on the one RAM read
// port and a write. A new request is taken once the response is loaded.
// Reset (synchronous, active high) empties the list, parks the cursor at none
// and drops any pending response; the RAM content is not cleared. While the
// receiver stalls, the response is held, and a following request may be taken
// and worked on but waits before its response is loaded.
module unsorted_list_table_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ulist_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [ulist_pkg::DATA_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic signed [ulist_pkg::DATA_W-1:0]   rsp_item_out,
   output logic [$clog2(DEPTH+1)-1:0]            rsp_count,
   output logic                                  rsp_full_res,
   output logic                                  rsp_rejected
);

   import ulist_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer and list state.
   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               cur_act_ff, cur_act_in;
   logic [AW-1:0]      cur_idx_ff, cur_idx_in;
   logic [CW-1:0]      lidx_ff, lidx_in;
   logic [AW-1:0]      ptr_ff, ptr_in;

   // Result being built and the output register.
   logic               res_found_ff, res_found_in;
   logic [DATA_W-1:0]  res_item_ff, res_item_in;
   logic               res_rej_ff, res_rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0]  rsp_item_ff, rsp_item_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_rej_ff, rsp_rej_in;

   // RAM port signals.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [DATA_W-1:0]  ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [DATA_W-1:0]  ram_rdata;

   // Physical addresses: logical position x lives at address count - 1 - x.
   logic [CW-1:0]      scan_phys;
   logic [CW-1:0]      cur_phys;

   assign scan_phys = count_ff - CW'(1) - lidx_ff;
   assign cur_phys  = count_ff - CW'(1) - CW'(cur_idx_ff);

   ulist_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      cur_act_in   = cur_act_ff;
      cur_idx_in   = cur_idx_ff;
      lidx_in      = lidx_ff;
      ptr_in       = ptr_ff;
      res_found_in = res_found_ff;
      res_item_in  = res_item_ff;
      res_rej_in   = res_rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_count_in = rsp_count_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_rej_in   = rsp_rej_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req_value;
      ram_raddr    = scan_phys[AW-1:0];

      // A response leaves when the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in      = mode_type'(req_mode);
               value_in     = req_value;
               res_found_in = 1'b0;
               res_item_in  = '0;
               res_rej_in   = 1'b0;
               lidx_in      = '0;
               state_in     = ST_RESP;
               case (mode_type'(req_mode))
                  MODE_INSERT: begin
                     // New front entry goes just above the current top.
                     if (count_ff == CW'(DEPTH)) begin
                        res_rej_in = 1'b1;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (cur_act_ff) begin
                           cur_idx_in = cur_idx_ff + AW'(1);
                        end
                     end
                  end
                  MODE_DELETE, MODE_RETRIEVE: begin
                     if (count_ff != '0) begin
                        state_in = ST_SC_RD;
                     end
                  end
                  MODE_RST_CUR: begin
                     cur_act_in = 1'b0;
                     cur_idx_in = '0;
                  end
                  MODE_GET_NEXT: begin
                     // Advance the cursor, wrapping to none after the last entry.
                     if (!cur_act_ff) begin
                        if (count_ff != '0) begin
                           cur_act_in = 1'b1;
                           cur_idx_in = '0;
                           state_in   = ST_GN_RD;
                        end
                     end else if (CW'(cur_idx_ff) + CW'(1) < count_ff) begin
                        cur_idx_in = cur_idx_ff + AW'(1);
                        state_in   = ST_GN_RD;
                     end else begin
                        cur_act_in = 1'b0;
                        cur_idx_in = '0;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in   = '0;
                     cur_act_in = 1'b0;
                     cur_idx_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SC_RD: begin
            ram_raddr = scan_phys[AW-1:0];
            state_in  = ST_SC_CMP;
         end

         ST_SC_CMP: begin
            // Compare one entry per visit, front to back.
            if (ram_rdata == value_ff) begin
               res_found_in = 1'b1;
               if (mode_ff == MODE_RETRIEVE) begin
                  res_item_in = value_ff;
                  state_in    = ST_RESP;
               end else begin
                  if (cur_act_ff) begin
                     if (CW'(cur_idx_ff) == lidx_ff) begin
                        cur_act_in = 1'b0;
                        cur_idx_in = '0;
                     end else if (CW'(cur_idx_ff) > lidx_ff) begin
                        cur_idx_in = cur_idx_ff - AW'(1);
                     end
                  end
                  ptr_in = scan_phys[AW-1:0];
                  // Entries ahead of the match sit above it and must move down.
                  if (lidx_ff != '0) begin
                     state_in = ST_SH_RD;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = ST_RESP;
                  end
               end
            end else if (lidx_ff + CW'(1) == count_ff) begin
               state_in = ST_RESP;
            end else begin
               lidx_in  = lidx_ff + CW'(1);
               state_in = ST_SC_RD;
            end
         end

         ST_SH_RD: begin
            ram_raddr = ptr_ff + AW'(1);
            state_in  = ST_SH_WR;
         end

         ST_SH_WR: begin
            // Move one entry down into the gap.
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff + AW'(1);
            if (CW'(ptr_ff) + CW'(2) < count_ff) begin
               state_in = ST_SH_RD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end

         ST_GN_RD: begin
            ram_raddr = cur_phys[AW-1:0];
            state_in  = ST_GN_DATA;
         end

         ST_GN_DATA: begin
            res_found_in = 1'b1;
            res_item_in  = ram_rdata;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_item_in  = res_item_ff;
               rsp_count_in = count_ff;
               rsp_full_in  = (count_ff == CW'(DEPTH));
               rsp_rej_in   = res_rej_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_act_ff   <= 1'b0;
         cur_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_act_ff   <= cur_act_in;
         cur_idx_ff   <= cur_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      value_ff     <= value_in;
      lidx_ff      <= lidx_in;
      ptr_ff       <= ptr_in;
      res_found_ff <= res_found_in;
      res_item_ff  <= res_item_in;
      res_rej_ff   <= res_rej_in;
      rsp_found_ff <= rsp_found_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_full_res = rsp_full_ff;
   assign rsp_rejected = rsp_rej_ff;

endmodule

/* src/ulist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ulist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
